>>> rtl/crca_pkg.sv
// Shared constants and controller/datapath interface types for the run cell allocator.
`default_nettype none

package crca_pkg;

    localparam int POOL_CELLS_DEF = 1024;
    localparam int MAX_RUN_DEF    = 64;

    // Datapath operations, one per controller step
    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLR,
        DP_LOAD,
        DP_A_INIT,
        DP_A_ADV,
        DP_A_STEP,
        DP_A_HIT,
        DP_A_HOP,
        DP_A_FAIL,
        DP_T_SETUP,
        DP_T_RD,
        DP_T_WR,
        DP_S_INIT,
        DP_S_STEP,
        DP_S_FIRST,
        DP_S_FREE,
        DP_S_LINK,
        DP_S_SPL1,
        DP_S_SPL2,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic alloc_bad;
        logic scan_done;
        logic scan_free;
        logic hop_fail;
        logic shrink_bad;
        logic ver_end;
        logic ver_taken;
        logic free_last;
        logic pool_full;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/contiguous_run_cell_allocator.sv
// Top level of the contiguous run cell allocator: controller, datapath and checks.
//
// Channel  Dir  Handshake           Payload (low bit up)
// s_*      in   s_tvalid/s_tready   tdata: base_index, run_length, keep_count; tuser: op
// m_*      out  m_tvalid/m_tready   tdata: run_start, cells_in_use, peak_in_use;
//                                   tuser: alloc_failed
//
// Reset starts a clearing pass over every cell that rebuilds the free ring;
// s_tready stays low until it ends.
// Allocate: check, advance the cursor, scan free cells from the cursor, hop along the
// ring after a gap, then take each cell of the run (unlink reads, then writes).
// A rejected allocate (too long or pool full) goes straight to the result.
// Shrink: check each cell of the tail, free each one, then splice the freed cells into
// the ring unless the ring was empty; a rejected shrink goes straight to the result.
// One transaction is worked at a time; the next is taken while a result waits in the
// output register, which holds until m_tready.
`default_nettype none

module contiguous_run_cell_allocator #(
    parameter int POOL_CELLS = crca_pkg::POOL_CELLS_DEF,
    parameter int MAX_RUN    = crca_pkg::MAX_RUN_DEF,
    parameter int IW         = $clog2(POOL_CELLS),
    parameter int LW         = $clog2(MAX_RUN + 1),
    parameter int KW         = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1,
    parameter int ITW        = ((IW + LW + KW + 7) / 8) * 8,
    parameter int OTW        = ((3 * IW + 2 + 7) / 8) * 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [ITW-1:0] s_tdata,   // base_index, run_length, keep_count, zero pad
    input  wire logic [0:0]     s_tuser,   // op: 0 allocate, 1 shrink
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [OTW-1:0]      m_tdata,   // run_start, cells_in_use, peak_in_use, zero pad
    output logic [0:0]          m_tuser    // alloc_failed
);

    localparam int CW = IW + 1;

    crca_pkg::ctrl_cmd_t  cmd;
    crca_pkg::dp_status_t status;

    crca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .item_op  (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    crca_dp #(
        .POOL_CELLS (POOL_CELLS),
        .MAX_RUN    (MAX_RUN),
        .IW         (IW),
        .LW         (LW),
        .KW         (KW),
        .ITW        (ITW),
        .OTW        (OTW)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser[0]),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser[0]),
        .cmd     (cmd),
        .status  (status)
    );

    // One transaction in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    // A failed allocate reports cell zero
    a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[IW-1:0] == '0))
        else $error("failed allocate with nonzero run_start");

    // Peak never below the current use count
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[IW+CW-1:IW] <= m_tdata[IW+2*CW-1:IW+CW]))
        else $error("peak_in_use below cells_in_use");

endmodule

`default_nettype wire

>>> rtl/crca_ctrl.sv
// Controller state machine: sequences clear, allocate, shrink and result steps.
`default_nettype none

module crca_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic                  item_op,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire crca_pkg::dp_status_t  status,
    output crca_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [14:0] {
        ST_INIT    = 15'b000000000000001,
        ST_IDLE    = 15'b000000000000010,
        ST_A_CHECK = 15'b000000000000100,
        ST_A_ADV   = 15'b000000000001000,
        ST_A_SCAN  = 15'b000000000010000,
        ST_A_HOP   = 15'b000000000100000,
        ST_T_RD    = 15'b000000001000000,
        ST_T_WR    = 15'b000000010000000,
        ST_S_CHECK = 15'b000000100000000,
        ST_S_VER   = 15'b000001000000000,
        ST_S_FREE  = 15'b000010000000000,
        ST_S_LINK  = 15'b000100000000000,
        ST_S_SPL1  = 15'b001000000000000,
        ST_S_SPL2  = 15'b010000000000000,
        ST_RESULT  = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = crca_pkg::DP_NOP;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.op = crca_pkg::DP_CLR;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = crca_pkg::DP_LOAD;
                    state_next = item_op ? ST_S_CHECK : ST_A_CHECK;
                end
            end
            ST_A_CHECK:
            begin
                if (status.alloc_bad)
                begin
                    cmd.op     = crca_pkg::DP_A_FAIL;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.op     = crca_pkg::DP_A_INIT;
                    state_next = ST_A_ADV;
                end
            end
            ST_A_ADV:
            begin
                cmd.op     = crca_pkg::DP_A_ADV;
                state_next = ST_A_SCAN;
            end
            ST_A_SCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.op     = crca_pkg::DP_T_SETUP;
                    state_next = ST_T_RD;
                end
                else if (status.scan_free)
                    cmd.op = crca_pkg::DP_A_STEP;
                else if (status.hop_fail)
                begin
                    cmd.op     = crca_pkg::DP_A_FAIL;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.op     = crca_pkg::DP_A_HIT;
                    state_next = ST_A_HOP;
                end
            end
            ST_A_HOP:
            begin
                cmd.op     = crca_pkg::DP_A_HOP;
                state_next = ST_A_SCAN;
            end
            ST_T_RD:
            begin
                if (status.scan_done)
                    state_next = ST_RESULT;
                else
                begin
                    cmd.op     = crca_pkg::DP_T_RD;
                    state_next = ST_T_WR;
                end
            end
            ST_T_WR:
            begin
                cmd.op     = crca_pkg::DP_T_WR;
                state_next = ST_T_RD;
            end
            ST_S_CHECK:
            begin
                if (status.shrink_bad)
                    state_next = ST_RESULT;
                else
                begin
                    cmd.op     = crca_pkg::DP_S_INIT;
                    state_next = ST_S_VER;
                end
            end
            ST_S_VER:
            begin
                if (status.ver_end)
                begin
                    cmd.op     = crca_pkg::DP_S_FIRST;
                    state_next = ST_S_FREE;
                end
                else if (!status.ver_taken)
                    state_next = ST_RESULT;
                else
                    cmd.op = crca_pkg::DP_S_STEP;
            end
            ST_S_FREE:
            begin
                cmd.op = crca_pkg::DP_S_FREE;
                if (status.free_last)
                    state_next = ST_S_LINK;
            end
            ST_S_LINK:
            begin
                cmd.op     = crca_pkg::DP_S_LINK;
                state_next = status.pool_full ? ST_RESULT : ST_S_SPL1;
            end
            ST_S_SPL1:
            begin
                cmd.op     = crca_pkg::DP_S_SPL1;
                state_next = ST_S_SPL2;
            end
            ST_S_SPL2:
            begin
                cmd.op     = crca_pkg::DP_S_SPL2;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    cmd.op     = crca_pkg::DP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.op == crca_pkg::DP_OUT)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

>>> rtl/crca_dp.sv
// Datapath: ring and taken memories, cursor, search registers, counters, result register.
`default_nettype none

module crca_dp #(
    parameter int POOL_CELLS = crca_pkg::POOL_CELLS_DEF,
    parameter int MAX_RUN    = crca_pkg::MAX_RUN_DEF,
    parameter int IW         = $clog2(POOL_CELLS),
    parameter int LW         = $clog2(MAX_RUN + 1),
    parameter int KW         = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1,
    parameter int ITW        = ((IW + LW + KW + 7) / 8) * 8,
    parameter int OTW        = ((3 * IW + 2 + 7) / 8) * 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [ITW-1:0]       s_tdata,
    input  wire logic                 s_tuser,
    output logic [OTW-1:0]            m_tdata,
    output logic                      m_tuser,
    input  wire crca_pkg::ctrl_cmd_t  cmd,
    output crca_pkg::dp_status_t      status
);

    localparam int CW = IW + 1;
    localparam int EW = ((IW > LW) ? IW : LW) + 1;
    localparam logic [CW-1:0] POOL_C = CW'(POOL_CELLS);
    localparam logic [EW-1:0] POOL_E = EW'(POOL_CELLS);
    localparam logic [IW-1:0] LAST_I = IW'(POOL_CELLS - 1);
    localparam logic [LW-1:0] MAX_L  = LW'(MAX_RUN);

    logic [IW-1:0] next_mem [POOL_CELLS];
    logic [IW-1:0] prev_mem [POOL_CELLS];
    logic          taken_mem [POOL_CELLS];

    logic [IW-1:0] next_q, prev_q;
    logic          taken_q;

    logic          next_we, prev_we, taken_we, taken_wd;
    logic [IW-1:0] next_wa, next_wd, prev_wa, prev_wd, taken_wa;
    logic [IW-1:0] next_ra, prev_ra, taken_ra;

    // architectural state
    logic [IW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] use_reg, use_next;
    logic [CW-1:0] peak_reg, peak_next;
    logic [EW-1:0] ptr_reg, ptr_next;

    // per-item work registers
    logic          shrink_reg, shrink_next;
    logic          fail_reg, fail_next;
    logic [IW-1:0] base_reg, base_next;
    logic [LW-1:0] len_reg, len_next;
    logic [KW-1:0] keep_reg, keep_next;
    logic [IW-1:0] saved_reg, saved_next;
    logic [IW-1:0] mark_reg, mark_next;
    logic [IW-1:0] start_reg, start_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] steps_reg, steps_next;

    logic [IW-1:0] ostart_reg, ostart_next;
    logic          ofail_reg, ofail_next;
    logic [CW-1:0] ouse_reg, ouse_next;
    logic [CW-1:0] opeak_reg, opeak_next;

    logic [EW-1:0] first_e, end_e, last_e;
    logic [IW-1:0] first_i, last_i, cell_i, ptr_i;
    logic [CW-1:0] freed_c;

    assign first_e = EW'(base_reg) + EW'(keep_reg);
    assign end_e   = EW'(base_reg) + EW'(len_reg);
    assign last_e  = end_e - EW'(1);
    assign first_i = first_e[IW-1:0];
    assign last_i  = last_e[IW-1:0];
    assign cell_i  = IW'(EW'(start_reg) + EW'(cnt_reg));
    assign ptr_i   = ptr_reg[IW-1:0];
    assign freed_c = CW'(len_reg - LW'(keep_reg));

    always_comb
    begin
        status.clr_last   = (ptr_i == LAST_I);
        status.alloc_bad  = (len_reg > MAX_L) || (use_reg >= POOL_C);
        status.scan_done  = (cnt_reg == len_reg);
        status.scan_free  = (ptr_reg < POOL_E) && !taken_q;
        status.hop_fail   = (cursor_reg == mark_reg) || (steps_reg == POOL_C);
        status.shrink_bad = (len_reg > MAX_L) || (LW'(keep_reg) >= len_reg) ||
                            (end_e > POOL_E);
        status.ver_end    = (ptr_reg == end_e);
        status.ver_taken  = taken_q;
        status.free_last  = (ptr_reg == last_e);
        status.pool_full  = (use_reg >= POOL_C);
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        use_next    = use_reg;
        peak_next   = peak_reg;
        ptr_next    = ptr_reg;
        shrink_next = shrink_reg;
        fail_next   = fail_reg;
        base_next   = base_reg;
        len_next    = len_reg;
        keep_next   = keep_reg;
        saved_next  = saved_reg;
        mark_next   = mark_reg;
        start_next  = start_reg;
        cnt_next    = cnt_reg;
        steps_next  = steps_reg;
        ostart_next = ostart_reg;
        ofail_next  = ofail_reg;
        ouse_next   = ouse_reg;
        opeak_next  = opeak_reg;

        next_we  = 1'b0;
        next_wa  = ptr_i;
        next_wd  = ptr_i;
        prev_we  = 1'b0;
        prev_wa  = ptr_i;
        prev_wd  = ptr_i;
        taken_we = 1'b0;
        taken_wa = ptr_i;
        taken_wd = 1'b0;
        next_ra  = cursor_reg;
        prev_ra  = cursor_reg;

        case (cmd.op)
            crca_pkg::DP_CLR:
            begin
                next_we  = 1'b1;
                next_wd  = (ptr_i == LAST_I) ? '0 : ptr_i + IW'(1);
                prev_we  = 1'b1;
                prev_wd  = (ptr_i == '0) ? LAST_I : ptr_i - IW'(1);
                taken_we = 1'b1;
                ptr_next = ptr_reg + EW'(1);
            end
            crca_pkg::DP_LOAD:
            begin
                shrink_next = s_tuser;
                base_next   = s_tdata[IW-1:0];
                len_next    = s_tdata[IW+LW-1:IW];
                keep_next   = s_tdata[IW+LW+KW-1:IW+LW];
                saved_next  = cursor_reg;
                fail_next   = 1'b0;
            end
            crca_pkg::DP_A_INIT:
            begin
                mark_next  = cursor_reg;
                start_next = cursor_reg;
                ptr_next   = EW'(cursor_reg);
                cnt_next   = '0;
                steps_next = '0;
            end
            crca_pkg::DP_A_ADV, crca_pkg::DP_A_HOP:
                cursor_next = next_q;
            crca_pkg::DP_A_STEP:
            begin
                cnt_next = cnt_reg + LW'(1);
                ptr_next = ptr_reg + EW'(1);
            end
            crca_pkg::DP_A_HIT:
            begin
                cnt_next   = '0;
                start_next = cursor_reg;
                ptr_next   = EW'(cursor_reg);
                steps_next = steps_reg + CW'(1);
            end
            crca_pkg::DP_A_FAIL:
            begin
                fail_next   = 1'b1;
                cursor_next = saved_reg;
            end
            crca_pkg::DP_T_SETUP:
                cnt_next = '0;
            crca_pkg::DP_T_RD:
            begin
                next_ra = cell_i;
                prev_ra = cell_i;
            end
            crca_pkg::DP_T_WR:
            begin
                if (cursor_reg == cell_i)
                    cursor_next = next_q;
                next_we  = 1'b1;
                next_wa  = prev_q;
                next_wd  = next_q;
                prev_we  = 1'b1;
                prev_wa  = next_q;
                prev_wd  = prev_q;
                taken_we = 1'b1;
                taken_wa = cell_i;
                taken_wd = 1'b1;
                use_next = use_reg + CW'(1);
                if (use_next > peak_reg)
                    peak_next = use_next;
                cnt_next = cnt_reg + LW'(1);
            end
            crca_pkg::DP_S_INIT, crca_pkg::DP_S_FIRST:
                ptr_next = first_e;
            crca_pkg::DP_S_STEP:
                ptr_next = ptr_reg + EW'(1);
            crca_pkg::DP_S_FREE:
            begin
                taken_we = 1'b1;
                next_we  = 1'b1;
                next_wd  = (ptr_reg == last_e) ? ptr_i : ptr_i + IW'(1);
                prev_we  = 1'b1;
                prev_wd  = (ptr_reg == first_e) ? ptr_i : ptr_i - IW'(1);
                ptr_next = ptr_reg + EW'(1);
            end
            crca_pkg::DP_S_LINK:
            begin
                // empty ring: freed cells close on themselves
                if (use_reg >= POOL_C)
                begin
                    prev_we     = 1'b1;
                    prev_wa     = first_i;
                    prev_wd     = last_i;
                    next_we     = 1'b1;
                    next_wa     = last_i;
                    next_wd     = first_i;
                    cursor_next = first_i;
                    use_next    = use_reg - freed_c;
                end
            end
            crca_pkg::DP_S_SPL1:
            begin
                prev_we = 1'b1;
                prev_wa = first_i;
                prev_wd = prev_q;
                next_we = 1'b1;
                next_wa = prev_q;
                next_wd = first_i;
            end
            crca_pkg::DP_S_SPL2:
            begin
                next_we  = 1'b1;
                next_wa  = last_i;
                next_wd  = cursor_reg;
                prev_we  = 1'b1;
                prev_wa  = cursor_reg;
                prev_wd  = last_i;
                use_next = use_reg - freed_c;
            end
            crca_pkg::DP_OUT:
            begin
                ostart_next = (!shrink_reg && !fail_reg) ? start_reg : '0;
                ofail_next  = !shrink_reg && fail_reg;
                ouse_next   = use_reg;
                opeak_next  = peak_reg;
            end
            default:
            begin
            end
        endcase
        taken_ra = ptr_next[IW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_wa] <= next_wd;
        next_q <= next_mem[next_ra];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        prev_q <= prev_mem[prev_ra];
    end

    always_ff @(posedge clk)
    begin
        if (taken_we)
            taken_mem[taken_wa] <= taken_wd;
        taken_q <= taken_mem[taken_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            use_reg    <= '0;
            peak_reg   <= '0;
            ptr_reg    <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            use_reg    <= use_next;
            peak_reg   <= peak_next;
            ptr_reg    <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shrink_reg <= shrink_next;
        fail_reg   <= fail_next;
        base_reg   <= base_next;
        len_reg    <= len_next;
        keep_reg   <= keep_next;
        saved_reg  <= saved_next;
        mark_reg   <= mark_next;
        start_reg  <= start_next;
        cnt_reg    <= cnt_next;
        steps_reg  <= steps_next;
        ostart_reg <= ostart_next;
        ofail_reg  <= ofail_next;
        ouse_reg   <= ouse_next;
        opeak_reg  <= opeak_next;
    end

    assign m_tdata = OTW'({opeak_reg, ouse_reg, ostart_reg});
    assign m_tuser = ofail_reg;

endmodule

`default_nettype wire
